// File: sv/acd_pkg.sv
// Shared types, constants and GF(2^8) helpers for the AES CBC decryptor.
// Used by every module of the block; depends on nothing.
package acd_pkg;

    localparam int BLK_W  = 128;
    localparam int WORD_W = 64;
    localparam int RK_ROWS = 15;
    localparam int RK_AW   = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W1   = 3'd2;
    localparam logic [2:0] REG_KEY_W2   = 3'd3;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;
    localparam logic [2:0] REG_IV_HIGH  = 3'd5;
    localparam logic [2:0] REG_IV_LOW   = 3'd6;

    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef struct packed {
        logic             en;
        logic [RK_AW-1:0] addr;
        logic [BLK_W-1:0] data;
    } t_rk_wr;

    localparam logic [7:0] C_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] C_INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {C_SBOX[w[31:24]], C_SBOX[w[23:16]], C_SBOX[w[15:8]], C_SBOX[w[7:0]]};
    endfunction

    // Byte k of a block sits in bits 127-8k down; column c holds bytes 4c..4c+3.
    function automatic logic [BLK_W-1:0] inv_shift_sub(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] o;
        int c;
        int r;
        int src;
        o = '0;
        for (c = 0; c < 4; c++) begin
            for (r = 0; r < 4; r++) begin
                src = (((c + 4 - r) % 4) * 4) + r;
                o[BLK_W-1-8*(c*4+r) -: 8] = C_INV_SBOX[s[BLK_W-1-8*src -: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [BLK_W-1:0] inv_mix(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] o;
        logic [7:0] a [4];
        logic [7:0] m2 [4];
        logic [7:0] m4 [4];
        logic [7:0] m8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        int c;
        int k;
        o = '0;
        for (c = 0; c < 4; c++) begin
            for (k = 0; k < 4; k++) begin
                a[k]  = s[BLK_W-1-8*(c*4+k) -: 8];
                m2[k] = xtime(a[k]);
                m4[k] = xtime(m2[k]);
                m8[k] = xtime(m4[k]);
                m9[k] = m8[k] ^ a[k];
                mb[k] = m8[k] ^ m2[k] ^ a[k];
                md[k] = m8[k] ^ m4[k] ^ a[k];
                me[k] = m8[k] ^ m4[k] ^ m2[k];
            end
            o[BLK_W-1-8*(c*4+0) -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
            o[BLK_W-1-8*(c*4+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
            o[BLK_W-1-8*(c*4+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
            o[BLK_W-1-8*(c*4+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
        end
        return o;
    endfunction

endpackage

// File: sv/aes_cbc_decrypt.sv
// AES-128/256 CBC decryptor. Each item is one 128-bit ciphertext block and
// gives one plaintext block. After reset or any key or key-size write the
// round keys are rebuilt, one key word per cycle (44 words for a 128-bit
// key, 60 for a 256-bit key), and no item is taken meanwhile. A block then
// passes through the core in a first state for the key addition, a round
// state for each middle round and a last state for the final round with the
// chaining XOR, each against a round key row read from the key store. The
// core takes the next block from the queue only as it finishes the current
// one. A two-entry queue sits in front of the core and a result register
// behind it, so input and output stall independently. The IV applies to
// items with tuser set.
module aes_cbc_decrypt import acd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [63:0]   i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // cipher_high [63:0], cipher_low [127:64]
    input  logic          s_axis_tuser,   // start_message
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata    // plain_high [63:0], plain_low [127:64]
);

    logic                   r_key_size;
    logic [3:0][WORD_W-1:0] r_key;
    logic [WORD_W-1:0]      r_iv_high;
    logic [WORD_W-1:0]      r_iv_low;

    logic                   key_chg;
    logic                   q_push;
    logic [BLK_W:0]         q_wdata;
    logic                   q_ready;
    logic                   q_valid;
    logic                   q_pop;
    logic [BLK_W:0]         q_rdata;
    t_rk_wr                 rk_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= 1'b0;
            r_key      <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_KEY_SIZE: r_key_size <= i_cfg_wdata[0];
                REG_KEY_W0:   r_key[0]   <= i_cfg_wdata;
                REG_KEY_W1:   r_key[1]   <= i_cfg_wdata;
                REG_KEY_W2:   r_key[2]   <= i_cfg_wdata;
                REG_KEY_W3:   r_key[3]   <= i_cfg_wdata;
                REG_IV_HIGH:  r_iv_high  <= i_cfg_wdata;
                REG_IV_LOW:   r_iv_low   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign key_chg = i_cfg_we && (i_cfg_addr <= REG_KEY_W3);

    acd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_chg  (key_chg),
        .i_key_size (r_key_size),
        .i_key      (r_key),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_s_data   (s_axis_tdata),
        .i_s_start  (s_axis_tuser),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata),
        .o_rk_wr    (rk_wr)
    );

    acd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    acd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_size (r_key_size),
        .i_iv       ({r_iv_high, r_iv_low}),
        .i_rk_wr    (rk_wr),
        .i_q_valid  (q_valid),
        .i_q_data   (q_rdata),
        .o_q_pop    (q_pop),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_data   (m_axis_tdata)
    );

endmodule

// File: sv/acd_front.sv
// Front end: key schedule sequencer and input intake for the CBC decryptor.
// Depends on acd_pkg; writes round key rows into the back end's store.
module acd_front import acd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_key_chg,
    input  logic                     i_key_size,
    input  logic [3:0][WORD_W-1:0]   i_key,
    input  logic                     i_s_valid,
    output logic                     o_s_ready,
    input  logic [BLK_W-1:0]         i_s_data,
    input  logic                     i_s_start,
    input  logic                     i_q_ready,
    output logic                     o_q_push,
    output logic [BLK_W:0]           o_q_data,
    output t_rk_wr                   o_rk_wr
);

    logic [5:0]  r_idx;
    logic [7:0]  r_rcon;
    logic        r_fresh;
    logic [31:0] r_win [8];

    logic        expand;
    logic        from_key;
    logic        is_rot;
    logic        is_sub;
    logic [63:0] kw;
    logic [31:0] tmp;
    logic [31:0] word;
    logic [31:0] far_tap;
    logic [5:0]  last_idx;

    assign expand   = !r_fresh && !i_key_chg;
    assign last_idx = i_key_size ? 6'd59 : 6'd43;
    assign from_key = i_key_size ? (r_idx < 6'd8) : (r_idx < 6'd4);
    assign is_rot   = (r_idx[1:0] == 2'd0) && (!i_key_size || !r_idx[2]);
    assign is_sub   = i_key_size && (r_idx[2:0] == 3'd4);
    assign far_tap  = i_key_size ? r_win[7] : r_win[3];
    assign kw       = i_key[r_idx[2:1]];

    always_comb begin
        tmp = r_win[0];
        if (is_rot) begin
            tmp = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'h0};
        end else if (is_sub) begin
            tmp = sub_word(r_win[0]);
        end
        if (from_key) begin
            word = r_idx[0] ? kw[31:0] : kw[63:32];
        end else begin
            word = far_tap ^ tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_key_chg) begin
            r_idx   <= '0;
            r_rcon  <= 8'h01;
            r_fresh <= 1'b0;
        end else if (expand) begin
            r_idx <= r_idx + 6'd1;
            if (is_rot && !from_key) begin
                r_rcon <= xtime(r_rcon);
            end
            if (r_idx == last_idx) begin
                r_fresh <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (expand) begin
            r_win[0] <= word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // A row of four words is complete after every fourth word.
    always_comb begin
        o_rk_wr.en   = expand && (r_idx[1:0] == 2'd3);
        o_rk_wr.addr = r_idx[5:2];
        o_rk_wr.data = {r_win[2], r_win[1], r_win[0], word};
    end

    assign o_s_ready = r_fresh && i_q_ready;
    assign o_q_push  = i_s_valid && o_s_ready;
    assign o_q_data  = {i_s_start, i_s_data[63:0], i_s_data[127:64]};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> r_fresh)
        else $error("item taken while round keys are stale");

endmodule

// File: sv/acd_fifo.sv
// Two-entry queue between the intake and the round core.
// Depends on acd_pkg for the item width.
module acd_fifo import acd_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [BLK_W:0] i_data,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output logic [BLK_W:0] o_data
);

    logic [BLK_W:0] r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 2'd2)
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("queue underflow");

endmodule

// File: sv/acd_back.sv
// Back end: round-iterative inverse cipher, CBC chaining and output register.
// Depends on acd_pkg; holds the round key store written by acd_front.
module acd_back import acd_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_key_size,
    input  logic [BLK_W-1:0] i_iv,
    input  t_rk_wr         i_rk_wr,
    input  logic           i_q_valid,
    input  logic [BLK_W:0] i_q_data,
    output logic           o_q_pop,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output logic [BLK_W-1:0] o_m_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIRST = 2'd1;
    localparam logic [1:0] S_ROUND = 2'd2;
    localparam logic [1:0] S_LAST  = 2'd3;

    logic [BLK_W-1:0] r_rk_mem [RK_ROWS];
    logic [BLK_W-1:0] r_rk_q;
    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [3:0]       r_rnd;
    logic [3:0]       n_rnd;
    logic [BLK_W-1:0] r_blk;
    logic [BLK_W-1:0] r_ct;
    logic             r_start;
    logic [BLK_W-1:0] r_chain;
    logic             r_out_valid;
    logic [BLK_W-1:0] r_out;

    logic [RK_AW-1:0] rd_addr;
    logic [3:0]       nr;
    logic [BLK_W-1:0] shsub;
    logic [BLK_W-1:0] plain;
    logic             out_free;
    logic             finish;

    assign nr       = i_key_size ? 4'd14 : 4'd10;
    assign shsub    = inv_shift_sub(r_blk);
    assign plain    = shsub ^ r_rk_q ^ (r_start ? i_iv : r_chain);
    assign out_free = !r_out_valid || i_m_ready;
    assign finish   = (r_state == S_LAST) && out_free;
    assign o_q_pop  = i_q_valid && ((r_state == S_IDLE) || finish);

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        rd_addr = nr;
        case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    n_state = S_FIRST;
                    n_rnd   = nr - 4'd1;
                end
            end
            S_FIRST: begin
                rd_addr = r_rnd;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                rd_addr = r_rnd - 4'd1;
                n_rnd   = r_rnd - 4'd1;
                if (r_rnd == 4'd1) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                rd_addr = '0;
                if (finish) begin
                    if (o_q_pop) begin
                        rd_addr = nr;
                        n_state = S_FIRST;
                        n_rnd   = nr - 4'd1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_rk_wr.en) begin
            r_rk_mem[i_rk_wr.addr] <= i_rk_wr.data;
        end
        r_rk_q <= r_rk_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            if (finish) begin
                r_out_valid <= 1'b1;
                r_chain     <= r_ct;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ct    <= i_q_data[BLK_W-1:0];
            r_start <= i_q_data[BLK_W];
        end
        case (r_state)
            S_FIRST: r_blk <= r_ct ^ r_rk_q;
            S_ROUND: r_blk <= inv_mix(shsub ^ r_rk_q);
            default: r_blk <= r_blk;
        endcase
        if (finish) begin
            r_out <= plain;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = {r_out[63:0], r_out[127:64]};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_rnd != 4'd0) && (r_rnd < nr))
        else $error("round counter out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_valid && !i_m_ready) |=> $stable(r_out))
        else $error("pending result overwritten");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE) || (r_state == S_LAST))
        else $error("item taken mid-cipher");

endmodule

// File: tb/aes_cbc_decrypt_check.sv
`timescale 1ns / 100ps
// Checker for the AES CBC decryptor: watches the config port and both streams,
// predicts each plaintext block with its own AES model and compares. Needs acd_pkg.
module aes_cbc_decrypt_check import acd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [63:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results
);

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_plain;

    t_plain      plain_fifo[$];
    logic [7:0]  sbox_fwd [256];
    logic [7:0]  sbox_inv [256];
    logic        wide_key;
    logic [63:0] key_word [4];
    logic [63:0] iv_word [2];
    logic [63:0] prev_cipher [2];
    logic [31:0] sched [60];
    logic        sched_valid;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int n = 0; n < 8; n++) begin
            if (b[0]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return acc;
    endfunction

    // The S-box is derived from the field inverse followed by the affine map.
    initial begin
        logic [7:0] inv_v;
        logic [7:0] y;
        for (int x = 0; x < 256; x++) begin
            inv_v = 8'h00;
            for (int z = 1; z < 256; z++)
                if (x != 0 && gf_mul(x[7:0], z[7:0]) == 8'h01) inv_v = z[7:0];
            y = inv_v ^ {inv_v[6:0], inv_v[7]} ^ {inv_v[5:0], inv_v[7:6]}
                ^ {inv_v[4:0], inv_v[7:5]} ^ {inv_v[3:0], inv_v[7:4]} ^ 8'h63;
            sbox_fwd[x] = y;
            sbox_inv[y] = x[7:0];
        end
    end

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox_fwd[w[31:24]], sbox_fwd[w[23:16]], sbox_fwd[w[15:8]], sbox_fwd[w[7:0]]};
    endfunction

    task automatic build_schedule();
        int nk;
        int total;
        logic [31:0] t;
        logic [7:0]  rc;
        nk = wide_key ? 8 : 4;
        total = wide_key ? 60 : 44;
        rc = 8'h01;
        for (int i = 0; i < 60; i++) sched[i] = '0;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_word[i >> 1][31:0] : key_word[i >> 1][63:32];
        for (int i = nk; i < total; i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
        sched_valid = 1'b1;
    endtask

    function automatic logic [127:0] inv_cipher(input logic [127:0] blk);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] a [4];
        logic [31:0] k;
        int nr;
        logic [127:0] res;
        nr = wide_key ? 14 : 10;
        for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
        for (int r = nr; r >= 0; r--) begin
            if (r != nr) begin
                tmp = st;
                for (int rw = 0; rw < 4; rw++)
                    for (int c = 0; c < 4; c++)
                        st[c*4+rw] = sbox_inv[tmp[((c + 4 - rw) % 4) * 4 + rw]];
            end
            for (int c = 0; c < 4; c++) begin
                k = sched[r*4+c];
                st[c*4]   ^= k[31:24];
                st[c*4+1] ^= k[23:16];
                st[c*4+2] ^= k[15:8];
                st[c*4+3] ^= k[7:0];
            end
            if (r != nr && r != 0) begin
                for (int c = 0; c < 4; c++) begin
                    for (int j = 0; j < 4; j++) a[j] = st[c*4+j];
                    st[c*4]   = gf_mul(a[0], 8'h0e) ^ gf_mul(a[1], 8'h0b)
                              ^ gf_mul(a[2], 8'h0d) ^ gf_mul(a[3], 8'h09);
                    st[c*4+1] = gf_mul(a[0], 8'h09) ^ gf_mul(a[1], 8'h0e)
                              ^ gf_mul(a[2], 8'h0b) ^ gf_mul(a[3], 8'h0d);
                    st[c*4+2] = gf_mul(a[0], 8'h0d) ^ gf_mul(a[1], 8'h09)
                              ^ gf_mul(a[2], 8'h0e) ^ gf_mul(a[3], 8'h0b);
                    st[c*4+3] = gf_mul(a[0], 8'h0b) ^ gf_mul(a[1], 8'h0d)
                              ^ gf_mul(a[2], 8'h09) ^ gf_mul(a[3], 8'h0e);
                end
            end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    always @(posedge i_clk) begin
        logic [63:0]  c_hi;
        logic [63:0]  c_lo;
        logic [127:0] dec;
        t_plain       want;
        t_plain       got;
        if (!i_rst_n) begin
            plain_fifo.delete();
            wide_key = 1'b0;
            for (int i = 0; i < 4; i++) key_word[i] = '0;
            iv_word[0] = '0;
            iv_word[1] = '0;
            prev_cipher[0] = '0;
            prev_cipher[1] = '0;
            sched_valid = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_KEY_SIZE: begin wide_key = i_cfg_wdata[0]; sched_valid = 1'b0; end
                    REG_KEY_W0:   begin key_word[0] = i_cfg_wdata; sched_valid = 1'b0; end
                    REG_KEY_W1:   begin key_word[1] = i_cfg_wdata; sched_valid = 1'b0; end
                    REG_KEY_W2:   begin key_word[2] = i_cfg_wdata; sched_valid = 1'b0; end
                    REG_KEY_W3:   begin key_word[3] = i_cfg_wdata; sched_valid = 1'b0; end
                    REG_IV_HIGH:  iv_word[0] = i_cfg_wdata;
                    REG_IV_LOW:   iv_word[1] = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (!sched_valid) build_schedule();
                c_hi = s_axis_tdata[63:0];
                c_lo = s_axis_tdata[127:64];
                dec = inv_cipher({c_hi, c_lo});
                if (s_axis_tuser) begin
                    want.plain_high = dec[127:64] ^ iv_word[0];
                    want.plain_low  = dec[63:0] ^ iv_word[1];
                end else begin
                    want.plain_high = dec[127:64] ^ prev_cipher[0];
                    want.plain_low  = dec[63:0] ^ prev_cipher[1];
                end
                prev_cipher[0] = c_hi;
                prev_cipher[1] = c_lo;
                plain_fifo.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.plain_high = m_axis_tdata[63:0];
                got.plain_low  = m_axis_tdata[127:64];
                o_results++;
                if (plain_fifo.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: plaintext %h_%h arrived with none expected",
                                 $realtime, got.plain_high, got.plain_low);
                end else begin
                    want = plain_fifo.pop_front();
                    if (got.plain_high !== want.plain_high || got.plain_low !== want.plain_low) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: plaintext mismatch, expected %h_%h got %h_%h",
                                     $realtime, want.plain_high, want.plain_low,
                                     got.plain_high, got.plain_low);
                    end
                end
            end
        end
        o_pending = plain_fifo.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_results = 0;
    end

endmodule

// File: tb/aes_cbc_decrypt_test.sv
`timescale 1ns / 100ps
// Top of the AES CBC decryptor testbench: clock, reset, configuration and
// block stimulus with random stalls. Depends on acd_pkg and aes_cbc_decrypt_check.
module aes_cbc_decrypt_test import acd_pkg::*; ();

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_addr;
    logic [63:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;

    int fail_count;
    int pending;
    int results;
    int src_idle_pct;
    int dst_idle_pct;
    int blocks_sent;
    int cfg_writes;
    int quiet_cycles;

    aes_cbc_decrypt u_top (.*);

    aes_cbc_decrypt_check u_check (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Watchdog: any handshake or config write restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 6000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_block(input logic [63:0] c_hi, input logic [63:0] c_lo,
                              input logic st);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c_lo, c_hi};
        s_axis_tuser  <= st;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        blocks_sent++;
    endtask

    // Holds off the sender until every block is back, then lets the core settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic load_key(input logic wide, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        cfg_write(REG_KEY_SIZE, {63'h0, wide});
        cfg_write(REG_KEY_W0, k0);
        cfg_write(REG_KEY_W1, k1);
        cfg_write(REG_KEY_W2, k2);
        cfg_write(REG_KEY_W3, k3);
        cfg_write(REG_IV_HIGH, rand64());
        cfg_write(REG_IV_LOW, rand64());
        cfg_done();
    endtask

    task automatic send_messages(input int count);
        int left;
        int len;
        left = count;
        while (left > 0) begin
            len = $urandom_range(8, 1);
            for (int j = 0; j < len && left > 0; j++) begin
                // Mostly well-formed chains; now and then a stray restart.
                send_block(rand64(), rand64(), (j == 0) || ($urandom_range(19) == 0));
                left--;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        quiet_cycles = 0;
        blocks_sent = 0;
        cfg_writes = 0;
        src_idle_pct = 13;
        dst_idle_pct = 88;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset key of zeros, chaining from the zero reset value without a start.
        send_block(64'h0, 64'h0, 1'b0);
        send_block({64{1'b1}}, {64{1'b1}}, 1'b0);
        send_block(64'h0, 64'h0, 1'b1);
        wait_drained();

        load_key(1'b0, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, {64{1'b1}}, {64{1'b1}});
        cfg_write(3'd7, {64{1'b1}});
        cfg_done();
        send_block(64'h7649abac8119b246, 64'hcee98e9b12e9197d, 1'b1);
        send_block(64'h5086cb9b507219ee, 64'h95db113a917678b2, 1'b0);
        send_block({64{1'b1}}, 64'h0, 1'b0);
        send_block(64'h0, {64{1'b1}}, 1'b1);
        wait_drained();
        // IV change mid-message only shows at the next start.
        cfg_write(REG_IV_HIGH, {64{1'b1}});
        cfg_write(REG_IV_LOW, {64{1'b1}});
        cfg_done();
        send_block(rand64(), rand64(), 1'b0);
        send_block(rand64(), rand64(), 1'b1);
        wait_drained();

        load_key(1'b1, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
        send_block(64'h0, 64'h0, 1'b1);
        send_block({64{1'b1}}, {64{1'b1}}, 1'b0);
        send_block(rand64(), rand64(), 1'b0);
        wait_drained();
        load_key(1'b1, 64'h0, 64'h0, 64'h0, 64'h0);
        send_block(rand64(), rand64(), 1'b1);
        send_block(rand64(), rand64(), 1'b0);
        wait_drained();

        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 88 : 0;
            dst_idle_pct = (mode == 0) ? 88 : (mode == 1) ? 13 : 0;
            for (int ph = 0; ph < 4; ph++) begin
                load_key($urandom_range(1), rand64(), rand64(), rand64(), rand64());
                send_messages(107);
                wait_drained();
            end
        end

        $display("Deciphered %0d blocks over %0d config writes, 128- and 256-bit keys,",
                 blocks_sent, cfg_writes);
        $display("with message restarts, IV changes and three stall patterns.");
        if (fail_count == 0 && pending == 0 && results == blocks_sent) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
